[hdl/mfa_pkg.sv]
// -----------------------------------------------------------------------------
// mfa_pkg: shared types and codes for the maximum-flow engine
// Operation codes, status codes, a register address, fixed field widths and the sequencer states.
// -----------------------------------------------------------------------------
package mfa_pkg;

  localparam int FLOW_W   = 20;
  localparam int VCOUNT_W = 5;
  localparam int VTX_W    = 4;
  localparam int CAPIN_W  = 16;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_COMPUTE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CLEAR = 13'b0000000000010,
    S_COPY  = 13'b0000000000100,
    S_BINIT = 13'b0000000001000,
    S_SCAN  = 13'b0000000010000,
    S_DRAIN = 13'b0000000100000,
    S_NEXT  = 13'b0000001000000,
    S_MIN   = 13'b0000010000000,
    S_MINE  = 13'b0000100000000,
    S_UPDA  = 13'b0001000000000,
    S_UPDB  = 13'b0010000000000,
    S_UPDC  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

endpackage

[hdl/max_flow_adjacency_matrix.sv]
// -----------------------------------------------------------------------------
// max_flow_adjacency_matrix: Edmonds-Karp maximum flow over a capacity matrix
// Capacity memory, residual memory and a sequencer that runs breadth-first
// search and path augmentation one memory access a cycle.
// -----------------------------------------------------------------------------
// A write command lands in the capacity memory and busy stays low, so writes
// can follow every cycle. A clear command, and reset itself, sweeps all
// 2^(2*ceil(log2(MAX_VERTICES))) words of the capacity memory (256 at the
// defaults), one word a cycle. A compute command holds busy for a time that
// depends on the data, all set by the single read port of the residual
// memory: a copy sweep of the same words, then per augmenting path a set-up
// state, a search that scans the row of each vertex reached, a walk for the
// smallest residual on the path and an update of each of its edges. The last
// search fails, and the done state then returns the word. A bad request
// (source equal to sink, or either at or above the vertex count) answers on
// the next cycle. Each result is shown for one cycle on done; there is no
// back-pressure, so the receiver must take the word when done is high.
// -----------------------------------------------------------------------------
module max_flow_adjacency_matrix
  import mfa_pkg::*;
#(
  parameter int MAX_VERTICES  = 16,
  parameter int CAPACITY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  // command side
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation,
  input  logic [VTX_W-1:0]    from_vertex,
  input  logic [VTX_W-1:0]    to_vertex,
  input  logic [CAPIN_W-1:0]  capacity,
  // result side
  output logic                done,
  output logic [FLOW_W-1:0]   max_flow,
  output logic                status,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW    = VW + 1;
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = CAPACITY_BITS;
  localparam int RW    = CAPACITY_BITS + 2;

  state_t state;

  logic [VCOUNT_W-1:0] vertex_count;

  // capacity memory ports
  logic          cap_we;
  logic [AW-1:0] cap_waddr;
  logic [CW-1:0] cap_wdata;
  logic [CW-1:0] cap_rdata;

  // residual memory ports
  logic          res_we;
  logic [AW-1:0] res_waddr;
  logic [RW-1:0] res_wdata;
  logic [AW-1:0] res_raddr;
  logic [RW-1:0] res_rdata;

  // sweep counter for clearing and copying
  logic [AW-1:0] sweep;
  logic          cp_pend;
  logic [AW-1:0] cp_addr;

  // search state
  logic [NW-1:0]     n_r;
  logic [VW-1:0]     src;
  logic [VW-1:0]     snk;
  logic [MAX_VERTICES-1:0] visited;
  logic [VW-1:0]     parent [MAX_VERTICES];
  logic [VW-1:0]     queue  [MAX_VERTICES];
  logic [NW-1:0]     head;
  logic [NW-1:0]     tail;
  logic [VW-1:0]     wcnt;
  logic              chk;
  logic [VW-1:0]     chk_w;

  // augmentation state
  logic [VW-1:0]     wv;
  logic [VW-1:0]     pu;
  logic              mn_pend;
  logic              mn_first;
  logic [RW-1:0]     push;
  logic [FLOW_W-1:0] flow_total;
  logic [FLOW_W+RW-1:0] flow_sum;

  logic [NW-1:0]     n_eff;
  logic              accept;
  logic              bad_req;
  logic [VW-1:0]     u_cur;
  logic [NW-1:0]     head_next;
  logic              cfg_wr;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign n_eff = (32'(vertex_count) < MAX_VERTICES) ? NW'(vertex_count)
                                                    : NW'(MAX_VERTICES);
  assign bad_req = (from_vertex == to_vertex)
                || (32'(from_vertex) >= 32'(n_eff))
                || (32'(to_vertex) >= 32'(n_eff));

  assign u_cur     = queue[head[VW-1:0]];
  assign pu        = parent[wv];
  assign head_next = head + NW'(1);
  assign flow_sum  = {{RW{1'b0}}, flow_total} + {{FLOW_W{1'b0}}, push};

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_W'(16);
    end else if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
      vertex_count <= pwdata[VCOUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vertex_count) : 32'd0;

  // capacity memory: sweep clears it, write commands land directly
  always_comb begin
    cap_we    = 1'b0;
    cap_waddr = {VW'(from_vertex), VW'(to_vertex)};
    cap_wdata = CW'(capacity);
    if (state == S_CLEAR) begin
      cap_we    = 1'b1;
      cap_waddr = sweep;
      cap_wdata = '0;
    end else if (accept && operation == OP_WRITE
                 && 32'(from_vertex) < MAX_VERTICES
                 && 32'(to_vertex) < MAX_VERTICES) begin
      cap_we = 1'b1;
    end
  end

  mfa_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cap_ram (
    .clk     (clk),
    .wr_en   (cap_we),
    .wr_addr (cap_waddr),
    .wr_data (cap_wdata),
    .rd_addr (sweep),
    .rd_data (cap_rdata)
  );

  // residual memory: copy writes, then the shared subtract/add on path edges
  always_comb begin
    res_we    = 1'b0;
    res_waddr = cp_addr;
    res_wdata = RW'(cap_rdata);
    res_raddr = {u_cur, wcnt};
    if (cp_pend) begin
      res_we = 1'b1;
    end else if (state == S_UPDB) begin
      res_we    = 1'b1;
      res_waddr = {pu, wv};
      res_wdata = res_rdata - push;
    end else if (state == S_UPDC) begin
      res_we    = 1'b1;
      res_waddr = {wv, pu};
      res_wdata = res_rdata + push;
    end
    if (state == S_MIN || state == S_UPDA) begin
      res_raddr = {pu, wv};
    end else if (state == S_UPDB) begin
      res_raddr = {wv, pu};
    end
  end

  mfa_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_res_ram (
    .clk     (clk),
    .wr_en   (res_we),
    .wr_addr (res_waddr),
    .wr_data (res_wdata),
    .rd_addr (res_raddr),
    .rd_data (res_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sweep      <= '0;
      cp_pend    <= 1'b0;
      chk        <= 1'b0;
      mn_pend    <= 1'b0;
      done       <= 1'b0;
      flow_total <= '0;
    end else begin
      done    <= 1'b0;
      cp_pend <= 1'b0;
      chk     <= 1'b0;
      mn_pend <= 1'b0;

      // late compare of a searched edge: mark, record parent, enqueue
      if (chk && res_rdata != '0 && !visited[chk_w]) begin
        visited[chk_w]          <= 1'b1;
        parent[chk_w]           <= u_cur;
        queue[tail[VW-1:0]]     <= chk_w;
        tail                    <= tail + NW'(1);
      end

      // late compare on the path: keep the smallest residual
      if (mn_pend) begin
        mn_first <= 1'b0;
        if (mn_first || res_rdata < push) begin
          push <= res_rdata;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (operation)
              OP_CLEAR: begin
                sweep <= '0;
                state <= S_CLEAR;
              end
              OP_COMPUTE: begin
                if (bad_req) begin
                  flow_total <= '0;
                  max_flow   <= '0;
                  status     <= STATUS_ERR;
                  done       <= 1'b1;
                end else begin
                  n_r        <= n_eff;
                  src        <= VW'(from_vertex);
                  snk        <= VW'(to_vertex);
                  flow_total <= '0;
                  sweep      <= '0;
                  state      <= S_COPY;
                end
              end
              default: begin
                // write commands go straight to the memory; code 3 is dropped
              end
            endcase
          end
        end
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_COPY: begin
          cp_pend <= 1'b1;
          cp_addr <= sweep;
          sweep   <= sweep + AW'(1);
          if (sweep == AW'(DEPTH - 1)) begin
            state <= S_BINIT;
          end
        end
        S_BINIT: begin
          visited     <= MAX_VERTICES'(1) << src;
          parent[src] <= src;
          queue[0]    <= src;
          head        <= '0;
          tail        <= NW'(1);
          wcnt        <= '0;
          state       <= S_SCAN;
        end
        S_SCAN: begin
          chk   <= 1'b1;
          chk_w <= wcnt;
          if (NW'(wcnt) == n_r - NW'(1)) begin
            state <= S_DRAIN;
          end else begin
            wcnt <= wcnt + VW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_NEXT;
        end
        S_NEXT: begin
          head <= head_next;
          wcnt <= '0;
          if (head_next == tail) begin
            if (visited[snk]) begin
              wv       <= snk;
              mn_first <= 1'b1;
              state    <= S_MIN;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_SCAN;
          end
        end
        S_MIN: begin
          mn_pend <= 1'b1;
          wv      <= pu;
          if (pu == src) begin
            state <= S_MINE;
          end
        end
        S_MINE: begin
          wv    <= snk;
          state <= S_UPDA;
        end
        S_UPDA: begin
          state <= S_UPDB;
        end
        S_UPDB: begin
          state <= S_UPDC;
        end
        S_UPDC: begin
          wv <= pu;
          if (pu == src) begin
            flow_total <= flow_sum[FLOW_W-1:0];
            state      <= S_BINIT;
          end else begin
            state <= S_UPDA;
          end
        end
        S_DONE: begin
          max_flow <= flow_total;
          status   <= STATUS_OK;
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/mfa_ram.sv]
// -----------------------------------------------------------------------------
// mfa_ram: generic single-write, single-read memory
// One write port and one read port; read data registered.
// -----------------------------------------------------------------------------
module mfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/mfa_checker.sv]
// -----------------------------------------------------------------------------
// mfa_checker: port-level checks for the maximum-flow engine
// Watches the command and result ports; bound to the top level.
// -----------------------------------------------------------------------------
module mfa_checker
  import mfa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [1:0]        operation,
  input logic              done,
  input logic [FLOW_W-1:0] max_flow,
  input logic              status
);

  // an error word carries no flow
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_ERR |-> max_flow == '0)
    else $error("error word with nonzero flow");

  // a good result only ends a search, never comes from an idle cycle
  a_ok_after_busy: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_OK |-> $past(busy))
    else $error("good word without prior search");

  // an edge write gives no word
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && operation == OP_WRITE |=> !done)
    else $error("word after edge write");

  // a clear command starts its sweep, so the block is busy right after it
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && operation == OP_CLEAR |=> busy)
    else $error("clear did not start sweep");

endmodule

bind max_flow_adjacency_matrix mfa_checker u_mfa_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .operation (operation),
  .done      (done),
  .max_flow  (max_flow),
  .status    (status)
);
